FILE: sv/kmp_pkg.sv
// kmp_pkg: shared codes and types for the kmp pattern matcher
// holds command codes, field widths and the command beat passed from front to back
// no dependencies
package kmp_pkg;

    localparam int SYM_W  = 8;
    localparam int FUNC_W = 2;
    localparam int POS_W  = 32;

    localparam logic [FUNC_W-1:0] FUNC_CLEAR   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_APPEND  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_TEXT    = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_RESTART = 2'd3;

    typedef struct packed {
        logic clear;
        logic append;
        logic text;
        logic restart;
    } t_kind;

    typedef struct packed {
        t_kind             kind;
        logic [SYM_W-1:0]  symbol;
    } t_cmd;

endpackage

FILE: sv/kmp_pattern_matcher.sv
// kmp_pattern_matcher: knuth-morris-pratt matcher, top level
// a text beat is decoded in idle, walks the failure chain, and on a full match passes the fall
// state, which waits for a free output register before loading the match position
// kmp_back takes a new command only when idle; the front queue holds beats while a walk runs
// synchronous active-low reset clears lengths, text position, queue and output register
module kmp_pattern_matcher #(
    parameter int MAX_PATTERN = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_tvalid,
    output logic                        o_s_tready,
    input  logic [kmp_pkg::SYM_W-1:0]   i_s_tdata,   // symbol
    input  logic [kmp_pkg::FUNC_W-1:0]  i_s_tuser,   // func
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    output logic [kmp_pkg::POS_W-1:0]   o_m_tdata    // match_position
);
    import kmp_pkg::*;

    logic cmd_valid;
    logic cmd_ready;
    t_cmd cmd;

    kmp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_cmd_valid (cmd_valid),
        .i_cmd_ready (cmd_ready),
        .o_cmd       (cmd)
    );

    kmp_back #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .o_cmd_ready (cmd_ready),
        .i_cmd       (cmd),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata)
    );

endmodule

FILE: sv/kmp_front.sv
// kmp_front: input side of the kmp pattern matcher
// accepts stream beats, decodes the function code and queues commands (two deep)
// depends on kmp_pkg
module kmp_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_s_tvalid,
    output logic                         o_s_tready,
    input  logic [kmp_pkg::SYM_W-1:0]    i_s_tdata,   // symbol
    input  logic [kmp_pkg::FUNC_W-1:0]   i_s_tuser,   // func
    output logic                         o_cmd_valid,
    input  logic                         i_cmd_ready,
    output kmp_pkg::t_cmd                o_cmd
);
    import kmp_pkg::*;

    t_cmd       r_q [0:1];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;
    logic       push;
    logic       pop;
    t_cmd       in_cmd;

    always_comb begin
        in_cmd.kind   = '0;
        in_cmd.symbol = i_s_tdata;
        case (i_s_tuser)
            FUNC_CLEAR:   in_cmd.kind.clear   = 1'b1;
            FUNC_APPEND:  in_cmd.kind.append  = 1'b1;
            FUNC_TEXT:    in_cmd.kind.text    = 1'b1;
            FUNC_RESTART: in_cmd.kind.restart = 1'b1;
            default:      in_cmd.kind         = '0;
        endcase
    end

    assign o_s_tready  = (r_cnt != 2'd2);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rd];
    assign push        = i_s_tvalid && o_s_tready;
    assign pop         = o_cmd_valid && i_cmd_ready;

    always_comb begin
        n_cnt = r_cnt;
        if (push && !pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (pop && !push) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr] <= in_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (push) begin
                r_wr <= ~r_wr;
            end
            if (pop) begin
                r_rd <= ~r_rd;
            end
        end
    end

endmodule

FILE: sv/kmp_back.sv
// kmp_back: sequencer of the kmp pattern matcher
// holds pattern and failure memories, walks the failure chain, emits match beats
// depends on kmp_pkg
module kmp_back #(
    parameter int MAX_PATTERN = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cmd_valid,
    output logic                        o_cmd_ready,
    input  kmp_pkg::t_cmd               i_cmd,
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    output logic [kmp_pkg::POS_W-1:0]   o_m_tdata
);
    import kmp_pkg::*;

    localparam int LW = $clog2(MAX_PATTERN + 1);
    localparam int IW = $clog2(MAX_PATTERN);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_WALK = 2'd1;
    localparam logic [1:0] S_FALL = 2'd2;

    localparam logic signed [LW:0] K_NONE = '1;
    localparam logic signed [LW:0] K_ONE  = (LW+1)'(1);
    localparam logic signed [LW:0] K_ZERO = '0;

    logic [1:0]             r_state, n_state;
    logic [LW-1:0]          r_len, n_len;
    logic signed [LW:0]     r_bp, n_bp;
    logic [LW-1:0]          r_ml, n_ml;
    logic [POS_W-1:0]       r_tp, n_tp;
    logic [POS_W-1:0]       r_pos, n_pos;
    logic signed [LW:0]     r_k, n_k;
    logic [SYM_W-1:0]       r_c, n_c;
    logic                   r_build, n_build;
    logic                   r_m_valid, n_m_valid;
    logic [POS_W-1:0]       r_m_data, n_m_data;

    logic [SYM_W-1:0]       r_pat_mem [0:MAX_PATTERN-1];
    logic [IW-1:0]          r_fail_mem [0:MAX_PATTERN-1];
    logic [SYM_W-1:0]       r_pat_q;
    logic [IW-1:0]          r_fail_q;

    logic                   hit;
    logic signed [LW:0]     res;
    logic signed [LW:0]     fail_k;
    logic                   out_free;
    logic                   wr_en;
    logic [IW-1:0]          p_addr;
    logic [IW-1:0]          f_addr;

    assign o_cmd_ready = (r_state == S_IDLE);
    assign o_m_tvalid  = r_m_valid;
    assign o_m_tdata   = r_m_data;

    // minus one needs no lookup and always extends
    assign hit      = r_k[LW] || (r_pat_q == r_c);
    assign res      = r_k + K_ONE;
    assign fail_k   = $signed((LW+1)'(r_fail_q));
    assign out_free = !r_m_valid || i_m_tready;

    always_comb begin
        n_state   = r_state;
        n_len     = r_len;
        n_bp      = r_bp;
        n_ml      = r_ml;
        n_tp      = r_tp;
        n_pos     = r_pos;
        n_k       = r_k;
        n_c       = r_c;
        n_build   = r_build;
        n_m_valid = r_m_valid;
        n_m_data  = r_m_data;
        wr_en     = 1'b0;
        if (r_m_valid && i_m_tready) begin
            n_m_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    n_c = i_cmd.symbol;
                    if (i_cmd.kind.clear) begin
                        n_len = '0;
                        n_bp  = K_NONE;
                        n_ml  = '0;
                    end else if (i_cmd.kind.restart) begin
                        n_tp = '0;
                        n_ml = '0;
                    end else if (i_cmd.kind.append) begin
                        if (r_len < LW'(MAX_PATTERN)) begin
                            n_k     = r_bp;
                            n_build = 1'b1;
                            n_state = S_WALK;
                        end
                    end else if (i_cmd.kind.text) begin
                        n_pos = r_tp;
                        n_tp  = r_tp + POS_W'(1);
                        if (r_len == '0) begin
                            n_ml = '0;
                        end else begin
                            n_k     = $signed({1'b0, r_ml});
                            n_build = 1'b0;
                            n_state = S_WALK;
                        end
                    end
                end
            end
            S_WALK: begin
                if (!hit) begin
                    n_k = (r_k == K_ZERO) ? K_NONE : fail_k;
                end else if (r_build) begin
                    wr_en   = 1'b1;
                    n_bp    = res;
                    n_len   = r_len + LW'(1);
                    n_state = S_IDLE;
                end else if (res[LW-1:0] == r_len) begin
                    n_state = S_FALL;
                end else begin
                    n_ml    = res[LW-1:0];
                    n_state = S_IDLE;
                end
            end
            S_FALL: begin
                if (out_free) begin
                    n_m_valid = 1'b1;
                    n_m_data  = r_pos + POS_W'(1) - POS_W'(r_len);
                    n_ml      = LW'(r_fail_q);
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // failure entry j lives at index j-1, entry zero is implicit
    assign p_addr = n_k[IW-1:0];
    assign f_addr = (n_state == S_FALL) ? IW'(r_len - LW'(1))
                                        : (n_k[IW-1:0] - IW'(1));

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_pat_mem[r_len[IW-1:0]]  <= r_c;
            r_fail_mem[r_len[IW-1:0]] <= res[IW-1:0];
        end
        r_pat_q  <= r_pat_mem[p_addr];
        r_fail_q <= r_fail_mem[f_addr];
    end

    always_ff @(posedge i_clk) begin
        r_pos    <= n_pos;
        r_k      <= n_k;
        r_c      <= n_c;
        r_build  <= n_build;
        r_m_data <= n_m_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_len     <= '0;
            r_bp      <= K_NONE;
            r_ml      <= '0;
            r_tp      <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_len     <= n_len;
            r_bp      <= n_bp;
            r_ml      <= n_ml;
            r_tp      <= n_tp;
            r_m_valid <= n_m_valid;
        end
    end

    // walk only ever reads pattern bytes already written
    a_walk_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> (r_k < $signed({1'b0, r_len})))
        else $error("failure walk left the loaded pattern");

    a_bp_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_len == '0) == (r_bp == K_NONE))
        else $error("build prefix out of step with pattern length");

    a_ml_short: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ml < r_len) || (r_ml == '0))
        else $error("matched length not shorter than pattern");

    a_fall_from_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FALL) && ($past(r_state) != S_FALL) |-> ($past(r_state) == S_WALK))
        else $error("fallback entered without a walk");

    a_fall_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FALL) && out_free |=> r_m_valid)
        else $error("match not placed in output register");

endmodule

FILE: dv/kmp_match_checker.sv
// kmp_match_checker: tracks the command and match streams of kmp_pattern_matcher and
// predicts every match position, comparing each result beat with the oldest prediction
// depends on kmp_pkg for the command codes and field widths
module kmp_match_checker #(
    parameter int MAX_PATTERN = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_tvalid,
    input  logic                        i_s_tready,
    input  logic [kmp_pkg::SYM_W-1:0]   i_s_tdata,   // symbol
    input  logic [kmp_pkg::FUNC_W-1:0]  i_s_tuser,   // func
    input  logic                        i_m_tvalid,
    input  logic                        i_m_tready,
    input  logic [kmp_pkg::POS_W-1:0]   i_m_tdata,   // match_position
    output int                          o_errors,
    output int                          o_outstanding
);

    import kmp_pkg::*;

    logic [SYM_W-1:0] pat_mem [MAX_PATTERN];
    int               border_tab [MAX_PATTERN+1];
    int               pat_len;
    int               build_k;
    int               match_k;
    logic [POS_W-1:0] text_pos;
    logic [POS_W-1:0] match_pos_q [$];
    int               errors;

    initial begin
        errors = 0;
    end

    // follow the border chain from k until c extends a prefix
    function automatic int extend_border(int k, logic [SYM_W-1:0] c);
        int guard;
        guard = 0;
        while (k >= 0 && k < MAX_PATTERN && pat_mem[k] != c && guard <= MAX_PATTERN) begin
            k = border_tab[k];
            guard++;
        end
        if (k < -1 || k >= MAX_PATTERN) begin
            k = -1;
        end
        return k + 1;
    endfunction

    task automatic track_command(logic [FUNC_W-1:0] f, logic [SYM_W-1:0] c);
        logic [POS_W-1:0] pos;
        case (f)
            FUNC_CLEAR: begin
                pat_len       = 0;
                build_k       = -1;
                border_tab[0] = -1;
                match_k       = 0;
            end
            FUNC_RESTART: begin
                text_pos = '0;
                match_k  = 0;
            end
            FUNC_APPEND: begin
                if (pat_len < MAX_PATTERN) begin
                    pat_mem[pat_len] = c;
                    build_k = (pat_len == 0) ? 0 : extend_border(build_k, c);
                    border_tab[pat_len+1] = build_k;
                    pat_len++;
                end
            end
            default: begin
                pos      = text_pos;
                text_pos = text_pos + POS_W'(1);
                if (pat_len == 0) begin
                    match_k = 0;
                end else begin
                    match_k = extend_border(match_k, c);
                    if (match_k >= pat_len) begin
                        match_pos_q.push_back(pos + 32'd1 - POS_W'(pat_len));
                        match_k = border_tab[pat_len];
                        if (match_k < 0) begin
                            match_k = 0;
                        end
                    end
                end
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        logic [POS_W-1:0] want;
        if (!i_rst_n) begin
            pat_len       = 0;
            build_k       = -1;
            match_k       = 0;
            text_pos      = '0;
            foreach (border_tab[i]) border_tab[i] = 0;
            border_tab[0] = -1;
            match_pos_q.delete();
        end else begin
            if (i_s_tvalid && i_s_tready) begin
                track_command(i_s_tuser, i_s_tdata);
            end
            if (i_m_tvalid && i_m_tready) begin
                if (match_pos_q.size() == 0) begin
                    $error("match_position: expected none, got %0d", i_m_tdata);
                    errors++;
                end else begin
                    want = match_pos_q.pop_front();
                    if (i_m_tdata !== want) begin
                        $error("match_position: expected %0d, got %0d", want, i_m_tdata);
                        errors++;
                    end
                end
            end
        end
        o_errors      <= errors;
        o_outstanding <= match_pos_q.size();
    end

endmodule

FILE: dv/kmp_pattern_matcher_test.sv
// kmp_pattern_matcher_test: drives commands and text into kmp_pattern_matcher with random
// idling and a long output stall, and gives the verdict from kmp_match_checker's counts
// depends on kmp_pkg, kmp_pattern_matcher and kmp_match_checker
module kmp_pattern_matcher_test;

    import kmp_pkg::*;

    localparam int MAX_PATTERN = 64;
    localparam int TOTAL_BEATS = 1600;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_s_tvalid = 1'b0;
    logic                o_s_tready;
    logic [SYM_W-1:0]    i_s_tdata = '0;
    logic [FUNC_W-1:0]   i_s_tuser = '0;
    logic                o_m_tvalid;
    logic                i_m_tready = 1'b0;
    logic [POS_W-1:0]    o_m_tdata;

    int                  errors;
    int                  outstanding;
    int                  beats = 0;
    logic                calm = 1'b0;
    logic                hold_rx = 1'b0;
    logic                held = 1'b0;
    logic [SYM_W-1:0]    alpha [4];
    int                  alpha_n = 1;

    always #6 i_clk = ~i_clk;

    kmp_pattern_matcher #(
        .MAX_PATTERN (MAX_PATTERN)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    kmp_match_checker #(
        .MAX_PATTERN (MAX_PATTERN)
    ) i_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_s_tvalid    (i_s_tvalid),
        .i_s_tready    (o_s_tready),
        .i_s_tdata     (i_s_tdata),
        .i_s_tuser     (i_s_tuser),
        .i_m_tvalid    (o_m_tvalid),
        .i_m_tready    (i_m_tready),
        .i_m_tdata     (o_m_tdata),
        .o_errors      (errors),
        .o_outstanding (outstanding)
    );

    task automatic send_beat(logic [FUNC_W-1:0] f, logic [SYM_W-1:0] c);
        if (!calm && $urandom_range(0, 99) < 31) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= c;
        i_s_tuser  <= f;
        do @(posedge i_clk); while (!o_s_tready);
        beats++;
    endtask

    // the outstanding count is registered in the checker, so it lags the last accepted beat
    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
    endtask

    function automatic logic [SYM_W-1:0] pick_sym();
        return alpha[$urandom_range(0, alpha_n - 1)];
    endfunction

    // clear, load a mostly short pattern over a tiny alphabet, then text with copies of it
    task automatic run_match_phase();
        logic [SYM_W-1:0] pat [$];
        logic [SYM_W-1:0] c;
        int plen;
        int tlen;
        int n;
        int r;
        alpha_n = $urandom_range(1, 3);
        foreach (alpha[i]) alpha[i] = SYM_W'($urandom);
        plen = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 6);
        send_beat(FUNC_CLEAR, SYM_W'($urandom));
        repeat (plen) begin
            c = pick_sym();
            if (pat.size() < MAX_PATTERN) pat.push_back(c);
            send_beat(FUNC_APPEND, c);
        end
        if ($urandom_range(0, 2) == 0) send_beat(FUNC_RESTART, SYM_W'($urandom));
        tlen = $urandom_range(10, 50);
        n = 0;
        while (n < tlen) begin
            r = $urandom_range(0, 99);
            if (r < 25) begin
                foreach (pat[j]) send_beat(FUNC_TEXT, pat[j]);
                n += pat.size();
            end else if (r < 27 && pat.size() < MAX_PATTERN) begin
                c = pick_sym();
                pat.push_back(c);
                send_beat(FUNC_APPEND, c);
            end else if (r < 29) begin
                send_beat(FUNC_RESTART, SYM_W'($urandom));
                n++;
            end else begin
                send_beat(FUNC_TEXT, pick_sym());
                n++;
            end
        end
    endtask

    task automatic run_noise_phase();
        repeat ($urandom_range(10, 30)) begin
            send_beat(FUNC_W'($urandom_range(0, 3)), SYM_W'($urandom));
        end
    endtask

    // one-byte pattern and a text of that byte only, so every beat matches
    task automatic run_backpressure_phase();
        logic [SYM_W-1:0] c;
        c = SYM_W'($urandom);
        send_beat(FUNC_CLEAR, SYM_W'($urandom));
        send_beat(FUNC_APPEND, c);
        hold_rx = 1'b1;
        repeat (60) send_beat(FUNC_TEXT, c);
        wait_drained();
    endtask

    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_rx && !held) begin
                held = 1'b1;
                i_m_tready <= 1'b0;
                repeat (400) @(posedge i_clk);
            end else begin
                i_m_tready <= calm || ($urandom_range(0, 99) >= 31);
            end
        end
    end

    initial begin
        int phase;
        phase = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty pattern, overlapping hits, append while text runs, clear keeps position
        send_beat(FUNC_CLEAR, 8'hFF);
        send_beat(FUNC_TEXT, 8'hA5);
        send_beat(FUNC_RESTART, 8'hFF);
        send_beat(FUNC_APPEND, 8'h00);
        send_beat(FUNC_APPEND, 8'hFF);
        send_beat(FUNC_APPEND, 8'h00);
        send_beat(FUNC_TEXT, 8'h00);
        send_beat(FUNC_TEXT, 8'hFF);
        send_beat(FUNC_TEXT, 8'h00);
        send_beat(FUNC_TEXT, 8'hFF);
        send_beat(FUNC_TEXT, 8'h00);
        send_beat(FUNC_APPEND, 8'h55);
        send_beat(FUNC_TEXT, 8'h55);
        send_beat(FUNC_CLEAR, 8'h00);
        send_beat(FUNC_APPEND, 8'h7E);
        send_beat(FUNC_TEXT, 8'h7E);
        send_beat(FUNC_TEXT, 8'h7E);
        send_beat(FUNC_TEXT, 8'h7E);
        send_beat(FUNC_RESTART, 8'h00);
        send_beat(FUNC_TEXT, 8'h7E);
        wait_drained();

        run_backpressure_phase();
        while (beats < TOTAL_BEATS) begin
            calm = (beats > 700 && beats < 1000);
            if ($urandom_range(0, 99) < 80) begin
                run_match_phase();
            end else begin
                run_noise_phase();
            end
            phase++;
            if (phase % 9 == 0) wait_drained();
        end
        calm = 1'b0;
        wait_drained();
        repeat (40) @(posedge i_clk);
        if (errors == 0 && outstanding == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #24000000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
